// ===== design/tbd_pkg.sv =====
// Shared types and helpers for the tile bitstream decompressor.
// No dependencies; imported by tbd_core, tbd_outq and the top level.
package tbd_pkg;

	// Bitstream decode phase
	typedef enum logic [3:0] {
		PH_HEADER, PH_CNT_HI, PH_CNT_LO, PH_PIV_A, PH_PIV_B, PH_ROW,
		PH_PIX_HI, PH_PIX_LO, PH_SAME, PH_N0, PH_N1, PH_TFLAG, PH_DRAIN
	} phase_t;

	// Sequencer state of the core
	typedef enum logic [2:0] {
		C_IDLE, C_BITS, C_TAIL, C_REPEAT, C_PLANE1, C_FIN, C_FLUSH
	} ctl_t;

	// Result kinds
	localparam logic [1:0] KIND_TILE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_TRUNC = 2'd2;

	// Register indexes
	localparam logic REG_INVERT  = 1'b0;
	localparam logic REG_PERSIST = 1'b1;

	// One result word handed to the output stage
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [1:0] kind;
	} push_t;

	// Follow colors for a pivot a (already skipped past c): returns {b, d}
	function automatic logic [3:0] pivot_bd(input logic [1:0] a, input logic [1:0] c);
		logic [2:0] b;
		logic [2:0] d;
		if (a != 2'd0 && c != 2'd0) b = 3'd0;
		else if (a != 2'd1 && c != 2'd1) b = 3'd1;
		else b = 3'd2;
		d = b + 3'd1;
		if (d[1:0] == a || d[1:0] == c) d = d + 3'd1;
		if (d[1:0] == a || d[1:0] == c) d = d + 3'd1;
		return {b[1:0], d[1:0]};
	endfunction

endpackage

// ===== design/tbd_outq.sv =====
// Output stage: one hold word plus the stream output register.
// The hold word lets the end-of-step flag be set on the last result. Uses tbd_pkg.
module tbd_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  tbd_pkg::push_t push,
	input  logic           flush,
	output logic           go,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,   // out_byte
	output logic [1:0]     m_tuser,   // out_kind
	output logic           m_tlast    // last_of_run
);
	import tbd_pkg::*;

	logic       hv_q;
	logic [7:0] hb_q;
	logic [1:0] hk_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic [1:0] ok_q;
	logic       ol_q;

	// a new word can enter whenever the held word can move on
	assign go = !hv_q || !ov_q || m_tready;

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if ((push.valid || flush) && hv_q) ov_q <= 1'b1;
			else if (ov_q && m_tready) ov_q <= 1'b0;
			if (push.valid) hv_q <= 1'b1;
			else if (flush) hv_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if ((push.valid || flush) && hv_q) begin
			ob_q <= hb_q;
			ok_q <= hk_q;
			ol_q <= flush;
		end
		if (push.valid) begin
			hb_q <= push.data;
			hk_q <= push.kind;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = ob_q;
	assign m_tuser  = ok_q;
	assign m_tlast  = ol_q;
endmodule

// ===== design/tbd_core.sv =====
// Bit-serial decoder core: input byte shift register, follow table, row
// assembly and plane-1 row store. Depends on tbd_pkg.
module tbd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           invert_first_bit,
	input  logic           persistent_rows,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  logic           go,
	output tbd_pkg::push_t push,
	output logic           flush
);
	import tbd_pkg::*;

	ctl_t       ctl_q, ctl_d;
	phase_t     phase_q, phase_d;
	logic [7:0] shift_q, shift_d;
	logic [3:0] cnt_q, cnt_d;
	logic       last_q, last_d;
	logic       tail_q, tail_d;
	logic [7:0] tiles_q, tiles_d;
	logic       until_q, until_d;
	logic       ended_q, ended_d;
	logic [1:0] fcnt_q [4];
	logic [1:0] fcnt_d [4];
	logic [1:0] fcol_q [4][3];
	logic [1:0] fcol_d [4][3];
	logic [1:0] tcol_q, tcol_d;
	logic       part_q, part_d;
	logic [7:0] p0_q, p0_d;
	logic [7:0] p1_q, p1_d;
	logic [2:0] row_q, row_d;
	logic [2:0] pix_q, pix_d;
	logic [1:0] cur_q, cur_d;
	logic [2:0] pidx_q, pidx_d;
	logic [7:0] p1mem [8];

	logic       we;
	logic [7:0] wdata;
	logic       bit_v;
	logic [3:0] cnt_now;
	ctl_t       cont;
	logic       do_feed, do_place, do_rowdone, do_endc, do_pivot;
	logic [1:0] place_c, piv_a, piv_a2;
	logic [3:0] bd;
	logic [7:0] rd_byte, rd_p1, np0, np1;
	logic [1:0] cnt_cur;

	assign in_ready = (ctl_q == C_IDLE);
	assign bit_v    = (ctl_q == C_TAIL) ? 1'b0 : shift_q[7];
	assign cnt_now  = (ctl_q == C_BITS) ? cnt_q - 4'd1 : cnt_q;
	assign cnt_cur  = fcnt_q[cur_q];

	// where to go once the current bit and its follow-up work are done
	always_comb begin
		if (tail_q) cont = C_TAIL;
		else if (cnt_now != 4'd0) cont = C_BITS;
		else if (last_q) cont = C_TAIL;
		else cont = C_FLUSH;
	end

	always_comb begin
		ctl_d = ctl_q; phase_d = phase_q; shift_d = shift_q; cnt_d = cnt_q;
		last_d = last_q; tail_d = tail_q; tiles_d = tiles_q; until_d = until_q;
		ended_d = ended_q; fcnt_d = fcnt_q; fcol_d = fcol_q; tcol_d = tcol_q;
		part_d = part_q; p0_d = p0_q; p1_d = p1_q; row_d = row_q; pix_d = pix_q;
		cur_d = cur_q; pidx_d = pidx_q;
		push = '0; flush = 1'b0; we = 1'b0; wdata = p1_q;
		do_feed = 1'b0; do_place = 1'b0; do_rowdone = 1'b0; do_endc = 1'b0;
		do_pivot = 1'b0; place_c = cur_q; piv_a = 2'd0; piv_a2 = 2'd0; bd = '0;
		rd_byte = p0_q; rd_p1 = p1_q; np0 = p0_q; np1 = p1_q;

		// sequencer
		case (ctl_q)
			C_IDLE: begin
				if (in_valid) begin
					if (phase_q == PH_DRAIN) begin
						if (in_last) phase_d = PH_HEADER;
					end else begin
						ended_d = in_last;
						last_d  = in_last;
						tail_d  = 1'b0;
						if (phase_q == PH_HEADER) begin
							tiles_d = in_byte;
							until_d = (in_byte == 8'd0);
							for (int i = 0; i < 4; i++) begin
								fcnt_d[i] = 2'd0;
								for (int k = 0; k < 3; k++) fcol_d[i][k] = 2'd0;
							end
							p0_d = '0; p1_d = '0; row_d = '0; pix_d = '0;
							cur_d = '0; tcol_d = 2'd3; part_d = 1'b0;
							shift_d = '0; cnt_d = '0;
							phase_d = PH_CNT_HI;
							ctl_d = in_last ? C_TAIL : C_IDLE;
						end else begin
							shift_d = in_byte;
							cnt_d   = 4'd8;
							ctl_d   = C_BITS;
						end
					end
				end
			end
			C_BITS: begin
				if (go) begin
					shift_d = {shift_q[6:0], 1'b0};
					cnt_d   = cnt_now;
					ctl_d   = cont;
					do_feed = 1'b1;
				end
			end
			C_TAIL: begin
				if (go) begin
					ctl_d   = cont;
					do_feed = 1'b1;
				end
			end
			C_REPEAT: begin
				if (go) begin
					ctl_d    = cont;
					do_place = 1'b1;
				end
			end
			C_PLANE1: begin
				if (go) begin
					push.valid = 1'b1;
					push.data  = p1mem[pidx_q];
					push.kind  = KIND_TILE;
					pidx_d     = pidx_q + 3'd1;
					if (pidx_q == 3'd7) begin
						// tile end
						if (until_q) begin
							if (ended_q) begin
								ctl_d = C_FIN; part_d = 1'b0;
							end else begin
								phase_d = PH_TFLAG; ctl_d = cont;
							end
						end else if (tiles_q <= 8'd1) begin
							ctl_d = C_FIN; part_d = 1'b0;
						end else begin
							tiles_d = tiles_q - 8'd1;
							if (tail_q) begin
								ctl_d = C_FIN; part_d = 1'b1;
							end else begin
								phase_d = PH_TFLAG; ctl_d = cont;
							end
						end
					end
				end
			end
			C_FIN: begin
				// part_q carries the truncation flag here
				if (go) begin
					push.valid = 1'b1;
					push.data  = 8'd0;
					push.kind  = part_q ? KIND_TRUNC : KIND_DONE;
					phase_d    = ended_q ? PH_HEADER : PH_DRAIN;
					ctl_d      = C_FLUSH;
				end
			end
			C_FLUSH: begin
				if (go) begin
					flush = 1'b1;
					ctl_d = C_IDLE;
				end
			end
			default: ctl_d = C_IDLE;
		endcase

		// one stream bit
		if (do_feed) begin
			case (phase_q)
				PH_CNT_HI: begin part_d = bit_v; phase_d = PH_CNT_LO; end
				PH_CNT_LO: begin
					fcnt_d[tcol_q] = {part_q, bit_v};
					if ({part_q, bit_v} == 2'd0) do_endc = 1'b1;
					else phase_d = PH_PIV_A;
				end
				PH_PIV_A: begin
					if (!bit_v) begin do_pivot = 1'b1; piv_a = 2'd0; end
					else phase_d = PH_PIV_B;
				end
				PH_PIV_B: begin do_pivot = 1'b1; piv_a = {bit_v, !bit_v}; end
				PH_ROW: begin
					if (bit_v) do_rowdone = 1'b1;
					else begin pix_d = 3'd0; phase_d = PH_PIX_HI; end
				end
				PH_PIX_HI: begin part_d = bit_v; phase_d = PH_PIX_LO; end
				PH_PIX_LO: begin do_place = 1'b1; place_c = {part_q, bit_v}; end
				PH_SAME: begin
					if (bit_v != invert_first_bit) do_place = 1'b1;
					else if (cnt_cur == 2'd1) begin
						do_place = 1'b1; place_c = fcol_q[cur_q][0];
					end else phase_d = PH_N0;
				end
				PH_N0: begin
					if (!bit_v) begin do_place = 1'b1; place_c = fcol_q[cur_q][0]; end
					else if (cnt_cur == 2'd2) begin
						do_place = 1'b1; place_c = fcol_q[cur_q][1];
					end else phase_d = PH_N1;
				end
				PH_N1: begin
					do_place = 1'b1;
					place_c  = bit_v ? fcol_q[cur_q][2] : fcol_q[cur_q][1];
				end
				PH_TFLAG: begin
					if (bit_v) begin tcol_d = 2'd3; phase_d = PH_CNT_HI; end
					else begin row_d = 3'd0; phase_d = PH_ROW; end
				end
				default: ;
			endcase
		end

		// pivot code: build the three follow colors of the table color
		if (do_pivot) begin
			piv_a2 = (piv_a >= tcol_q) ? piv_a + 2'd1 : piv_a;
			bd = pivot_bd(piv_a2, tcol_q);
			if (fcnt_q[tcol_q] == 2'd2) begin
				fcol_d[tcol_q][0] = bd[3:2];
				fcol_d[tcol_q][1] = bd[1:0];
			end else begin
				fcol_d[tcol_q][0] = piv_a2;
				fcol_d[tcol_q][1] = bd[3:2];
			end
			fcol_d[tcol_q][2] = bd[1:0];
			do_endc = 1'b1;
		end

		// next table color, or start the rows
		if (do_endc) begin
			if (tcol_q == 2'd0) begin
				if (!persistent_rows) begin p0_d = '0; p1_d = '0; end
				row_d = 3'd0;
				phase_d = PH_ROW;
			end else begin
				tcol_d = tcol_q - 2'd1;
				phase_d = PH_CNT_HI;
			end
		end

		// one pixel into the row planes
		if (do_place) begin
			np0   = {p0_q[6:0], place_c[0]};
			np1   = {p1_q[6:0], place_c[1]};
			cur_d = place_c;
			p0_d  = np0;
			p1_d  = np1;
			if (pix_q == 3'd7) begin
				do_rowdone = 1'b1;
				rd_byte = np0;
				rd_p1   = np1;
			end else begin
				pix_d = pix_q + 3'd1;
				if (fcnt_q[place_c] != 2'd0) phase_d = PH_SAME;
				else ctl_d = C_REPEAT;
			end
		end

		// row complete: plane-0 out now, plane-1 stored for tile end
		if (do_rowdone) begin
			push.valid = 1'b1;
			push.data  = rd_byte;
			push.kind  = KIND_TILE;
			we    = 1'b1;
			wdata = rd_p1;
			if (row_q == 3'd7) begin
				ctl_d  = C_PLANE1;
				pidx_d = 3'd0;
			end else begin
				row_d   = row_q + 3'd1;
				phase_d = PH_ROW;
			end
		end

		// entering zero-bit tail of the stream
		if (ctl_d == C_TAIL && ctl_q != C_TAIL) tail_d = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= C_IDLE; phase_q <= PH_HEADER; shift_q <= '0; cnt_q <= '0;
			last_q <= 1'b0; tail_q <= 1'b0; tiles_q <= '0; until_q <= 1'b0;
			ended_q <= 1'b0; tcol_q <= 2'd3; part_q <= 1'b0; p0_q <= '0;
			p1_q <= '0; row_q <= '0; pix_q <= '0; cur_q <= '0; pidx_q <= '0;
			for (int i = 0; i < 4; i++) begin
				fcnt_q[i] <= 2'd0;
				for (int k = 0; k < 3; k++) fcol_q[i][k] <= 2'd0;
			end
		end else begin
			ctl_q <= ctl_d; phase_q <= phase_d; shift_q <= shift_d; cnt_q <= cnt_d;
			last_q <= last_d; tail_q <= tail_d; tiles_q <= tiles_d;
			until_q <= until_d; ended_q <= ended_d; tcol_q <= tcol_d;
			part_q <= part_d; p0_q <= p0_d; p1_q <= p1_d; row_q <= row_d;
			pix_q <= pix_d; cur_q <= cur_d; pidx_q <= pidx_d;
			fcnt_q <= fcnt_d; fcol_q <= fcol_d;
		end
	end

	// plane-1 row store
	always_ff @(posedge clk) begin
		if (we) p1mem[row_q] <= wdata;
	end
endmodule

// ===== design/tile_bitstream_decompressor.sv =====
// Tile bitstream decompressor: register port, core and output stage.
// Depends on tbd_pkg, tbd_core and tbd_outq.
//
// Takes one compressed byte per word and decodes it one bit per clock while the
// output accepts: a data byte is accepted, shifted out bit by bit, and the step
// is then closed; a header byte is only accepted. A color that has no followers
// repeats at one pixel per cycle, the end of a tile adds the eight plane-1 bytes,
// and the last tile or a truncated stream adds an end marker. While two results
// wait on the output, decoding pauses until the sink takes one.
// The last result of each input byte carries m_tlast.
module tile_bitstream_decompressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [1:0]  m_tuser,   // out_kind
	output logic        m_tlast    // last_of_run
);
	import tbd_pkg::*;

	logic  invert_q, persist_q;
	logic  go, flush;
	push_t push;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q  <= 1'b0;
			persist_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_INVERT) invert_q <= pwdata[0];
			else persist_q <= pwdata[0];
		end
	end
	assign prdata = {31'd0, (paddr[2] == REG_PERSIST) ? persist_q : invert_q};

	tbd_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.invert_first_bit (invert_q),
		.persistent_rows  (persist_q),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.in_byte          (s_tdata),
		.in_last          (s_tlast),
		.go               (go),
		.push             (push),
		.flush            (flush)
	);

	tbd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.flush    (flush),
		.go       (go),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);
endmodule
